FILE: rtl/u8u16_pkg.sv
package u8u16_pkg;

    localparam int COUNT_BITS_DEF = 17;
    localparam int UNIT_W         = 16;
    localparam int UCNT_W         = 17;
    localparam int OUTQ_DEPTH     = 4;

    localparam logic [15:0] LIMIT_RST = 16'hFFFF;

    // lead byte class bounds
    localparam logic [7:0] LEAD3_MIN = 8'hE0;
    localparam logic [7:0] LEAD4_MIN = 8'hF0;

    // surrogate construction
    localparam logic [15:0] HI_BASE = 16'hD7C0;
    localparam logic [15:0] LO_BASE = 16'hDC00;
    localparam logic [9:0]  LO_MASK = 10'h3FF;

    typedef enum logic [1:0] {
        ST_DATA  = 2'd0,
        ST_END   = 2'd1,
        ST_BAD   = 2'd2,
        ST_LIMIT = 2'd3
    } t_status;

    typedef struct packed {
        logic [UNIT_W-1:0] unit;
        t_status           status;
        logic [UCNT_W-1:0] count;
        logic              last;
    } t_result;

    typedef struct packed {
        logic first;
        logic second;
    } t_push;

endpackage

FILE: rtl/u8u16_outq.sv
module u8u16_outq
    import u8u16_pkg::*;
#(
    parameter int DEPTH = OUTQ_DEPTH
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    input  t_result i_data0,
    input  t_result i_data1,
    output logic    o_room2,
    output logic    o_valid,
    input  logic    i_pop,
    output t_result o_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_result            r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr;
    logic [PTR_W-1:0]   r_rd;
    logic [CNT_W-1:0]   r_cnt;
    logic [PTR_W-1:0]   n_wr;
    logic [PTR_W-1:0]   n_rd;
    logic [CNT_W-1:0]   n_cnt;
    logic [PTR_W-1:0]   wr_nxt;
    logic               pop_ok;

    assign o_valid = (r_cnt != '0);
    assign o_room2 = (r_cnt <= CNT_W'(DEPTH - 2));
    assign o_data  = r_mem[r_rd];
    assign pop_ok  = i_pop && o_valid;
    assign wr_nxt  = r_wr + PTR_W'(1);

    always_comb begin
        n_wr  = r_wr + PTR_W'(i_push.first) + PTR_W'(i_push.second);
        n_rd  = r_rd + PTR_W'(pop_ok);
        n_cnt = r_cnt + CNT_W'(i_push.first) + CNT_W'(i_push.second) - CNT_W'(pop_ok);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.first) begin
            r_mem[r_wr] <= i_data0;
        end
        if (i_push.second) begin
            r_mem[wr_nxt] <= i_data1;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(DEPTH))
        else $error("output queue overflow");

    a_second_needs_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.second |-> i_push.first)
        else $error("second word pushed alone");

    a_pop_moves_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop_ok) |=> (r_rd == $past(r_rd) + PTR_W'(1)))
        else $error("read pointer did not advance on pop");

endmodule

FILE: rtl/utf8_to_utf16_decoder.sv
// UTF-8 to UTF-16 decoder, one input byte per cycle while o_in_ready is high.
// Result words are held in the registered output queue until o_out_valid and i_out_ready meet.
// Throughput: one byte per cycle while o_in_ready is high; a four-byte character gives two result
//   words in order. o_in_ready depends only on the four-word output queue having two free slots.
// Reset (synchronous, active low): sequence state and unit count cleared, unit_limit back to
//   65535, output queue emptied.
module utf8_to_utf16_decoder
    import u8u16_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration: unit_limit
    input  logic              i_cfg_we,
    input  logic [15:0]       i_cfg_data,
    // byte input
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [7:0]        i_in_byte,
    // result output
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [UNIT_W-1:0] o_unit,
    output logic [1:0]        o_status,
    output logic [UCNT_W-1:0] o_unit_count,
    output logic              o_run_last
);

    // compare width for units_written against the 16-bit limit
    localparam int CMP_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;

    // architectural state
    logic [15:0]           r_limit;
    logic [1:0]            r_exp;       // continuation bytes needed, 0 = at character start
    logic [1:0]            r_col;       // continuation bytes seen so far
    logic [7:0]            r_lead;
    logic [7:0]            r_c0;
    logic [7:0]            r_c1;
    logic [COUNT_BITS-1:0] r_units;     // saturating
    logic                  r_discard;   // dropping bytes up to the next NUL

    logic [1:0]            n_exp;
    logic [1:0]            n_col;
    logic [7:0]            n_lead;
    logic [7:0]            n_c0;
    logic [7:0]            n_c1;
    logic [COUNT_BITS-1:0] n_units;
    logic                  n_discard;

    logic                  acc;
    logic [7:0]            b;
    logic [COUNT_BITS-1:0] u1;
    logic [COUNT_BITS-1:0] u2;
    logic                  limit_hit;
    logic [1:0]            col_inc;
    logic [15:0]           v2;
    logic [15:0]           v3;
    logic [21:0]           v4;

    t_push                 push;
    t_result               res0;
    t_result               res1;
    t_result               q_out;
    logic                  room2;

    assign acc        = i_in_valid && o_in_ready;
    assign o_in_ready = room2;
    assign b          = i_in_byte;

    // two saturating increments in a row, the second only used by surrogate pairs
    assign u1 = (r_units == '1) ? r_units : r_units + COUNT_BITS'(1);
    assign u2 = (u1 == '1) ? u1 : u1 + COUNT_BITS'(1);

    assign limit_hit = (CMP_W'(r_units) >= CMP_W'(r_limit));
    assign col_inc   = r_col + 2'd1;

    // the masks overlap one bit between fields; the ORs keep that behavior
    assign v2 = 16'({r_lead[5:0], 6'd0}) | 16'(b[6:0]);
    assign v3 = {r_lead[3:0], 12'd0} | 16'({r_c0[6:0], 6'd0}) | 16'(b[6:0]);
    assign v4 = {r_lead[3:0], 18'd0} | 22'({r_c0[6:0], 12'd0})
              | 22'({r_c1[6:0], 6'd0}) | 22'(b[6:0]);

    always_comb begin
        n_exp     = r_exp;
        n_col     = r_col;
        n_lead    = r_lead;
        n_c0      = r_c0;
        n_c1      = r_c1;
        n_units   = r_units;
        n_discard = r_discard;
        push      = '0;

        res0.unit   = '0;
        res0.status = ST_DATA;
        res0.count  = UCNT_W'(r_units);
        res0.last   = 1'b1;
        res1.unit   = '0;
        res1.status = ST_DATA;
        res1.count  = UCNT_W'(u2);
        res1.last   = 1'b1;

        if (acc) begin
            if (r_discard) begin
                if (b == 8'd0) begin
                    n_discard = 1'b0;
                end
            end else if (r_exp == 2'd0) begin
                if (limit_hit || b == 8'd0) begin
                    // end of string; limit takes priority over NUL
                    push.first  = 1'b1;
                    res0.status = limit_hit ? ST_LIMIT : ST_END;
                    n_units     = '0;
                    n_discard   = limit_hit && (b != 8'd0);
                end else if (!b[7]) begin
                    push.first = 1'b1;
                    res0.unit  = {8'd0, b};
                    res0.count = UCNT_W'(u1);
                    n_units    = u1;
                end else begin
                    n_lead = b;
                    n_col  = 2'd0;
                    n_exp  = (b < LEAD3_MIN) ? 2'd1 : ((b < LEAD4_MIN) ? 2'd2 : 2'd3);
                end
            end else if (!b[7]) begin
                // bad continuation, NUL included
                push.first  = 1'b1;
                res0.status = ST_BAD;
                n_units     = '0;
                n_exp       = 2'd0;
                n_col       = 2'd0;
                n_discard   = (b != 8'd0);
            end else if (col_inc < r_exp) begin
                if (r_col == 2'd0) begin
                    n_c0 = b;
                end else begin
                    n_c1 = b;
                end
                n_col = col_inc;
            end else begin
                n_exp      = 2'd0;
                n_col      = 2'd0;
                push.first = 1'b1;
                res0.count = UCNT_W'(u1);
                n_units    = u1;
                unique case (r_exp)
                    2'd1: res0.unit = v2;
                    2'd2: res0.unit = v3;
                    default: begin
                        // surrogate pair, always written whole
                        push.second = 1'b1;
                        res0.unit   = 16'(v4[21:10]) + HI_BASE;
                        res0.last   = 1'b0;
                        res1.unit   = {6'd0, v4[9:0] & LO_MASK} + LO_BASE;
                        n_units     = u2;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit   <= LIMIT_RST;
            r_exp     <= 2'd0;
            r_col     <= 2'd0;
            r_units   <= '0;
            r_discard <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
            r_exp     <= n_exp;
            r_col     <= n_col;
            r_units   <= n_units;
            r_discard <= n_discard;
        end
    end

    // sequence bytes are only read after being written
    always_ff @(posedge i_clk) begin
        r_lead <= n_lead;
        r_c0   <= n_c0;
        r_c1   <= n_c1;
    end

    u8u16_outq #(
        .DEPTH (OUTQ_DEPTH)
    ) u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data0 (res0),
        .i_data1 (res1),
        .o_room2 (room2),
        .o_valid (o_out_valid),
        .i_pop   (i_out_ready),
        .o_data  (q_out)
    );

    assign o_unit       = q_out.unit;
    assign o_status     = q_out.status;
    assign o_unit_count = q_out.count;
    assign o_run_last   = q_out.last;

    a_pair_only_four_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.second |-> (r_exp == 2'd3 && acc))
        else $error("pair pushed outside a four-byte sequence");

    a_no_push_discard: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && r_discard) |-> !push.first)
        else $error("result produced while dropping input");

    a_bad_end_drops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push.first && (res0.status == ST_BAD || res0.status == ST_LIMIT) && b != 8'd0)
        |=> (r_discard && r_units == '0))
        else $error("error end did not start dropping");

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_DATA) |-> (o_run_last && o_unit == '0))
        else $error("end word malformed");

endmodule
